// ----- hw/rtl/upm_pkg.sv -----
// ============================================================================
// upm_pkg - shared types and constants for the alpha un-premultiply pipeline
// Pixel word types, per-channel divider lane state and the 8-bit scaling
// function used at the output stage.
// ============================================================================
package upm_pkg;

    // Fixed-point format: 1.15, one at 1 << FX_SHIFT
    localparam int CH_W      = 16;
    localparam int BYTE_W    = 8;
    localparam int FX_SHIFT  = 15;
    localparam int FX_ONE    = 1 << FX_SHIFT;
    localparam int FX_HALF   = FX_ONE / 2;
    localparam int BYTE_MAX  = 255;

    // Divider layout: 16 quotient bits, a fixed number of steps per stage
    localparam int QUO_W           = 16;
    localparam int STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES      = QUO_W / STEPS_PER_STAGE;
    localparam int NUM_COLOUR      = 3;

    // Colour lane order inside a bundle
    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;

    typedef struct packed {
        logic [CH_W-1:0] premult_red;
        logic [CH_W-1:0] premult_green;
        logic [CH_W-1:0] premult_blue;
        logic [CH_W-1:0] alpha_in;
    } t_pix_in;

    typedef struct packed {
        logic [BYTE_W-1:0] red_byte;
        logic [BYTE_W-1:0] green_byte;
        logic [BYTE_W-1:0] blue_byte;
        logic [BYTE_W-1:0] alpha_byte;
    } t_pix_out;

    // One colour channel in the divider: partial remainder, plus a shift
    // register that feeds dividend bits out of the top and takes quotient
    // bits in at the bottom.
    typedef struct packed {
        logic [CH_W-1:0]  rem;
        logic [QUO_W-1:0] sh;
        logic             ovf;
    } t_lane;

    typedef struct packed {
        t_lane [NUM_COLOUR-1:0] lane;
        logic [CH_W-1:0]        alpha;
        logic                   zero;
    } t_bundle;

    // (v * 255 + half) >> 15, saturated at 255
    function automatic logic [BYTE_W-1:0] to_byte(input logic [CH_W-1:0] v);
        logic [CH_W+9-1:0] prod;
        logic [9:0]        s;
        prod = {1'b0, v, 8'b0} - {9'b0, v} + (CH_W+9)'(FX_HALF);
        s    = prod[CH_W+9-1:FX_SHIFT];
        to_byte = (s > 10'(BYTE_MAX)) ? BYTE_W'(BYTE_MAX) : s[BYTE_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/rgba15_unpremultiply_to_rgba8.sv -----
// ============================================================================
// rgba15_unpremultiply_to_rgba8 - 1.15 premultiplied RGBA to straight RGBA8
// Divides each colour by alpha with rounding in a pipelined restoring
// divider, then scales all four channels to 8 bits with saturation.
// ============================================================================
//
//  channel | ports                     | word      | handshake
//  --------+---------------------------+-----------+-------------------------
//  pixel   | start, busy, i_pixel      | t_pix_in  | taken when start && !busy
//  result  | o_valid, o_result         | t_pix_out | one-cycle strobe, no hold
//
//  One pixel word may enter every clock cycle; busy is never raised.
//  The path runs through an input stage, four divider stages of
//  four restoring steps each, and an output scaling stage.
//  The 17-bit subtract chain inside each divider stage sets the clock.
//  Synchronous reset clears all valid bits; words in flight are dropped.
//  The receiver cannot stall, so the pipeline never holds.
//
module rgba15_unpremultiply_to_rgba8 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  upm_pkg::t_pix_in   i_pixel,
    output logic               o_valid,
    output upm_pkg::t_pix_out  o_result
);
    import upm_pkg::*;

    logic    w_take;
    logic    w_vld [DIV_STAGES+1];
    t_bundle w_bnd [DIV_STAGES+1];

    assign busy   = 1'b0;
    assign w_take = start && !busy;

    // Dividend set-up and range flags
    upm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_take),
        .i_pixel  (i_pixel),
        .o_valid  (w_vld[0]),
        .o_bundle (w_bnd[0])
    );

    // Divider stages
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        upm_div_stage u_stage (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (w_vld[g]),
            .i_bundle (w_bnd[g]),
            .o_valid  (w_vld[g+1]),
            .o_bundle (w_bnd[g+1])
        );
    end

    // Scaling to bytes
    upm_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_vld[DIV_STAGES]),
        .i_bundle (w_bnd[DIV_STAGES]),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // An accepted word shows up in the input stage next cycle
    a_front_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> w_vld[0])
        else $error("accepted word missing from input stage");

    // Last divider stage feeds the strobe in the following cycle
    a_out_strobe : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld[DIV_STAGES] |=> o_valid)
        else $error("result strobe missing after divider");

    // Zero alpha always comes out black
    a_zero_black : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld[DIV_STAGES] && w_bnd[DIV_STAGES].zero) |=>
        (o_result.red_byte == '0 && o_result.green_byte == '0 &&
         o_result.blue_byte == '0))
        else $error("zero alpha gave non-zero colour");

    // Red far above alpha saturates
    a_red_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld[DIV_STAGES] && !w_bnd[DIV_STAGES].zero &&
         w_bnd[DIV_STAGES].lane[LANE_RED].ovf) |=>
        (o_result.red_byte == BYTE_W'(BYTE_MAX)))
        else $error("red overflow did not saturate");

endmodule

// ----- hw/rtl/upm_front.sv -----
// ============================================================================
// upm_front - input stage of the un-premultiply pipeline
// Forms the rounded dividend (c << 15) + alpha / 2 for each colour, flags
// quotients that cannot fit 16 bits and zero alpha, and registers the result.
// ============================================================================
module upm_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  upm_pkg::t_pix_in   i_pixel,
    output logic               o_valid,
    output upm_pkg::t_bundle   o_bundle
);
    import upm_pkg::*;

    logic [CH_W-1:0] w_colour [NUM_COLOUR];
    logic [CH_W-1:0] w_alpha;
    t_bundle         n_bundle;
    t_bundle         r_bundle;
    logic            r_valid;

    assign w_colour[LANE_RED]   = i_pixel.premult_red;
    assign w_colour[LANE_GREEN] = i_pixel.premult_green;
    assign w_colour[LANE_BLUE]  = i_pixel.premult_blue;
    assign w_alpha              = i_pixel.alpha_in;

    // Dividend is {0, c, alpha[15:1]}: the rounding half never carries into c.
    // Upper half seeds the remainder; quotient >= 2^16 when it is >= alpha.
    always_comb begin
        n_bundle.alpha = w_alpha;
        n_bundle.zero  = (w_alpha == '0);
        for (int c = 0; c < NUM_COLOUR; c++) begin
            n_bundle.lane[c].rem = {1'b0, w_colour[c][CH_W-1:1]};
            n_bundle.lane[c].sh  = {w_colour[c][0], w_alpha[CH_W-1:1]};
            n_bundle.lane[c].ovf = ({1'b0, w_colour[c][CH_W-1:1]} >= w_alpha);
        end
    end

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_bundle <= n_bundle;
        end
    end

    assign o_valid  = r_valid;
    assign o_bundle = r_bundle;

endmodule

// ----- hw/rtl/upm_div_stage.sv -----
// ============================================================================
// upm_div_stage - one stage of the restoring divider
// Runs a fixed number of restoring steps on all three colour lanes against
// the shared alpha divisor and registers the lane state.
// ============================================================================
module upm_div_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  upm_pkg::t_bundle   i_bundle,
    output logic               o_valid,
    output upm_pkg::t_bundle   o_bundle
);
    import upm_pkg::*;

    t_bundle       n_bundle;
    t_bundle       r_bundle;
    logic          r_valid;
    logic [CH_W:0] v_cur;
    logic          v_fits;

    // Restoring steps: bring down one dividend bit, subtract alpha if it fits
    always_comb begin
        n_bundle = i_bundle;
        v_cur    = '0;
        v_fits   = 1'b0;
        for (int c = 0; c < NUM_COLOUR; c++) begin
            for (int s = 0; s < STEPS_PER_STAGE; s++) begin
                v_cur  = {n_bundle.lane[c].rem, n_bundle.lane[c].sh[QUO_W-1]};
                v_fits = (v_cur >= {1'b0, i_bundle.alpha});
                if (v_fits) begin
                    v_cur = v_cur - {1'b0, i_bundle.alpha};
                end
                n_bundle.lane[c].rem = v_cur[CH_W-1:0];
                n_bundle.lane[c].sh  = {n_bundle.lane[c].sh[QUO_W-2:0], v_fits};
            end
        end
    end

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_bundle <= n_bundle;
        end
    end

    assign o_valid  = r_valid;
    assign o_bundle = r_bundle;

endmodule

// ----- hw/rtl/upm_out.sv -----
// ============================================================================
// upm_out - output stage of the un-premultiply pipeline
// Scales quotients and alpha to 8 bits with rounding, applies the zero-alpha
// and overflow rules, and registers the result word with its strobe.
// ============================================================================
module upm_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  upm_pkg::t_bundle   i_bundle,
    output logic               o_valid,
    output upm_pkg::t_pix_out  o_result
);
    import upm_pkg::*;

    logic [BYTE_W-1:0] w_byte [NUM_COLOUR];
    t_pix_out          n_result;
    t_pix_out          r_result;
    logic              r_valid;

    // Zero alpha gives black; quotient past 16 bits is far above one: 255
    always_comb begin
        for (int c = 0; c < NUM_COLOUR; c++) begin
            if (i_bundle.zero) begin
                w_byte[c] = '0;
            end else if (i_bundle.lane[c].ovf) begin
                w_byte[c] = BYTE_W'(BYTE_MAX);
            end else begin
                w_byte[c] = to_byte(i_bundle.lane[c].sh);
            end
        end
        n_result.red_byte   = w_byte[LANE_RED];
        n_result.green_byte = w_byte[LANE_GREEN];
        n_result.blue_byte  = w_byte[LANE_BLUE];
        n_result.alpha_byte = to_byte(i_bundle.alpha);
    end

    // Strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- tb/rgba15_unpremultiply_to_rgba8_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// rgba15_unpremultiply_to_rgba8_test - self-checking bench for the RGBA8
// un-premultiply pipeline
// Sends pixel words through the start/busy port, back to back and with random
// gaps, and checks every result strobe against a bit-accurate software
// divide-and-scale model or a hand result. A short directed list covers zero
// alpha, opaque, colour above alpha and out-of-range channels. It is followed
// by random pixels, mostly well-formed premultiplied data.
// ============================================================================
module rgba15_unpremultiply_to_rgba8_test;
    import upm_pkg::*;

    typedef struct {
        t_pix_in  px;
        bit       typed;   // result given by hand
        t_pix_out res;
    } t_directed_row;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_pix_in  i_pixel;
    logic     o_valid;
    t_pix_out o_result;

    // Expected results, oldest first
    t_pix_out      expected_pixels[$];
    t_directed_row directed_rows[$];

    bit       word_taken;
    bit       gaps_on;
    bit       row_typed;
    t_pix_out row_result;
    int       fail_count;
    int       words_sent;
    int       results_checked;
    int       zero_alpha_words;
    int       over_alpha_words;
    int       wide_words;

    rgba15_unpremultiply_to_rgba8 i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_pixel  (i_pixel),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous run limit
    initial begin
        #3_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, expected_pixels.size());
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    // (c << 15 + a/2) / a, zero colour for zero alpha
    function automatic longint unsigned unpremultiply_channel(longint unsigned c,
                                                              longint unsigned a);
        if (a == 0)
            return 0;
        return ((c << FX_SHIFT) + (a >> 1)) / a;
    endfunction

    // (v * 255 + half) >> 15, saturated
    function automatic logic [BYTE_W-1:0] scale_to_byte(longint unsigned v);
        longint unsigned s;
        s = (v * BYTE_MAX + FX_HALF) >> FX_SHIFT;
        return (s > BYTE_MAX) ? BYTE_W'(BYTE_MAX) : s[BYTE_W-1:0];
    endfunction

    function automatic t_pix_out straight_pixel(t_pix_in p);
        t_pix_out r;
        r.red_byte   = scale_to_byte(unpremultiply_channel(p.premult_red, p.alpha_in));
        r.green_byte = scale_to_byte(unpremultiply_channel(p.premult_green, p.alpha_in));
        r.blue_byte  = scale_to_byte(unpremultiply_channel(p.premult_blue, p.alpha_in));
        r.alpha_byte = scale_to_byte(p.alpha_in);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------------
    function automatic t_pix_in pix(int unsigned r, int unsigned g, int unsigned b,
                                    int unsigned a);
        return '{premult_red: CH_W'(r), premult_green: CH_W'(g),
                 premult_blue: CH_W'(b), alpha_in: CH_W'(a)};
    endfunction

    function automatic t_pix_out bytes(int unsigned r, int unsigned g, int unsigned b,
                                       int unsigned a);
        return '{red_byte: BYTE_W'(r), green_byte: BYTE_W'(g),
                 blue_byte: BYTE_W'(b), alpha_byte: BYTE_W'(a)};
    endfunction

    // Mostly well-formed premultiplied pixels, the rest corner and wide data
    function automatic t_pix_in random_pixel();
        int unsigned pick;
        int unsigned a;
        pick = $urandom_range(99);
        a    = $urandom_range(FX_ONE, 1);
        if (pick < 58) begin
            // colour never above alpha
            return pix($urandom_range(a), $urandom_range(a), $urandom_range(a), a);
        end else if (pick < 68) begin
            return pix($urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                       $urandom_range(16'hFFFF), 0);
        end else if (pick < 78) begin
            // colour not below alpha, saturating
            return pix($urandom_range(FX_ONE, a), $urandom_range(FX_ONE, a),
                       $urandom_range(FX_ONE, a), a);
        end else if (pick < 88) begin
            return pix($urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                       $urandom_range(16'hFFFF), $urandom_range(16'hFFFF));
        end else if (pick < 94) begin
            return pix($urandom_range(FX_ONE), $urandom_range(FX_ONE),
                       $urandom_range(FX_ONE), FX_ONE);
        end else begin
            // tiny alpha, rounding at its sharpest
            a = $urandom_range(255, 1);
            return pix($urandom_range(2 * a), $urandom_range(2 * a),
                       $urandom_range(2 * a), a);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: called at a falling edge, returns at the falling edge after
    // the word was taken
    // ------------------------------------------------------------------------
    task automatic send_pixel(t_pix_in px);
        while (gaps_on && $urandom_range(99) < 34) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start   = 1'b1;
        i_pixel = px;
        if (px.alpha_in == 0)
            zero_alpha_words++;
        if (px.premult_red > px.alpha_in || px.premult_green > px.alpha_in
                || px.premult_blue > px.alpha_in)
            over_alpha_words++;
        if (px.alpha_in > FX_ONE || px.premult_red > FX_ONE
                || px.premult_green > FX_ONE || px.premult_blue > FX_ONE)
            wide_words++;
        do
            @(negedge i_clk);
        while (!word_taken);
    endtask

    task automatic check_field(string field, logic [BYTE_W-1:0] want,
                               logic [BYTE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch on result %0d, expected %0d, got %0d",
                     $time, field, results_checked, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: log taken words, check result strobes
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pix_out want;
        word_taken = i_rst_n && start && (busy === 1'b0);
        if (word_taken) begin
            want = row_typed ? row_result : straight_pixel(i_pixel);
            expected_pixels.push_back(want);
            words_sent++;
        end
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, o_result);
                fail_count++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("red_byte", want.red_byte, o_result.red_byte);
                check_field("green_byte", want.green_byte, o_result.green_byte);
                check_field("blue_byte", want.blue_byte, o_result.blue_byte);
                check_field("alpha_byte", want.alpha_byte, o_result.alpha_byte);
                results_checked++;
            end
        end else if (i_rst_n && o_valid !== 1'b0) begin
            $display("%0t: o_valid unknown, expected 0 or 1, got %b", $time, o_valid);
            fail_count++;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned waited;
        start      = 1'b0;
        i_pixel    = '0;
        i_rst_n    = 1'b0;
        row_typed  = 1'b0;
        row_result = '0;
        gaps_on    = 1'b1;
        word_taken = 1'b0;

        // Corner rows; hand results only where obvious
        directed_rows = '{
            '{pix(0, 0, 0, 0),                      1'b1, bytes(0, 0, 0, 0)},
            '{pix(32768, 32768, 32768, 32768),      1'b1, bytes(255, 255, 255, 255)},
            '{pix(0, 0, 0, 32768),                  1'b1, bytes(0, 0, 0, 255)},
            '{pix(65535, 65535, 65535, 0),          1'b1, bytes(0, 0, 0, 0)},
            '{pix(0, 0, 0, 65535),                  1'b1, bytes(0, 0, 0, 255)},
            '{pix(32768, 32768, 32768, 1),          1'b1, bytes(255, 255, 255, 0)},
            '{pix(65535, 65535, 65535, 65535),      1'b1, bytes(255, 255, 255, 255)},
            '{pix(16384, 16384, 16384, 16384),      1'b1, bytes(255, 255, 255, 128)},
            '{pix(1, 16384, 32767, 32768),          1'b0, '0},
            '{pix(0, 1, 0, 1),                      1'b0, '0},
            '{pix(1, 0, 2, 2),                      1'b0, '0},
            '{pix(1, 2, 3, 3),                      1'b0, '0},
            '{pix(32767, 16383, 128, 32767),        1'b0, '0},
            '{pix(128, 255, 257, 256),              1'b0, '0},
            '{pix(20000, 65535, 39999, 40000),      1'b0, '0},
            '{pix(64, 0, 127, 128),                 1'b0, '0},
            '{pix(0, 32, 64, 64),                   1'b0, '0},
            '{pix(33, 65, 32, 65),                  1'b0, '0},
            '{pix(43690, 21845, 65535, 43690),      1'b0, '0},
            '{pix(21845, 43690, 1, 21845),          1'b0, '0}
        };

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[n]) begin
            row_typed  = directed_rows[n].typed;
            row_result = directed_rows[n].res;
            send_pixel(directed_rows[n].px);
        end
        row_typed = 1'b0;

        // Back-to-back stretch first, then random gaps
        gaps_on = 1'b0;
        for (int n = 0; n < 1600; n++) begin
            if (n == 350)
                gaps_on = 1'b1;
            send_pixel(random_pixel());
        end
        start = 1'b0;

        waited = 0;
        while (expected_pixels.size() != 0 && waited < 1000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (16) @(negedge i_clk);
        if (expected_pixels.size() != 0) begin
            $display("%0t: %0d results never arrived, expected 0 outstanding",
                     $time, expected_pixels.size());
            fail_count++;
        end

        $display("Sent %0d pixel words, checked %0d results, %0d failures.",
                 words_sent, results_checked, fail_count);
        $display("Zero alpha: %0d, colour above alpha: %0d, channel above one: %0d.",
                 zero_alpha_words, over_alpha_words, wide_words);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
